>>> rtl/fes_pkg.sv
// fes_pkg: shared types and constants of the fade envelope sequencer
// no dependencies; imported by every module of the block
`default_nettype none

package fes_pkg;

    localparam int TIMER_W = 17;
    localparam int DUR_W   = 16;
    localparam int ALPHA_W = 8;
    localparam int ELAP_W  = 10;
    localparam int REM_W   = TIMER_W + ALPHA_W;

    localparam logic [TIMER_W-1:0] TIMER_MAX   = '1;
    localparam logic [ALPHA_W-1:0] ALPHA_FULL  = '1;
    localparam logic [DUR_W-1:0]   DUR_RESET   = 16'd750;

    localparam logic [1:0] FUNC_TICK    = 2'd0;
    localparam logic [1:0] FUNC_RESTART = 2'd1;
    localparam logic [1:0] FUNC_ALLOW   = 2'd2;

    localparam logic [1:0] REG_FADE_IN  = 2'd0;
    localparam logic [1:0] REG_HOLD     = 2'd1;
    localparam logic [1:0] REG_FADE_OUT = 2'd2;
    localparam logic [1:0] REG_PAUSE    = 2'd3;

    localparam logic [2:0] PHASE_IDLE     = 3'd0;
    localparam logic [2:0] PHASE_FADE_IN  = 3'd1;
    localparam logic [2:0] PHASE_HOLD     = 3'd2;
    localparam logic [2:0] PHASE_AT_MID   = 3'd3;
    localparam logic [2:0] PHASE_FADE_OUT = 3'd4;

    typedef struct packed {
        logic [1:0]        func;
        logic [ELAP_W-1:0] elapsed;
    } t_in_item;

    typedef struct packed {
        logic [ALPHA_W-1:0] alpha;
        logic               mid_event;
        logic               end_event;
        logic [2:0]         phase;
    } t_out_item;

    typedef struct packed {
        logic [DUR_W-1:0] fade_in_time;
        logic [DUR_W-1:0] hold_time;
        logic [DUR_W-1:0] fade_out_time;
        logic             pause_at_mid;
    } t_cfg;

    typedef struct packed {
        logic               start;
        logic [TIMER_W-1:0] t;
        logic [DUR_W-1:0]   d;
    } t_ramp_req;

    typedef struct packed {
        logic               done;
        logic [ALPHA_W-1:0] quotient;
    } t_ramp_rsp;

    typedef enum logic [2:0] {
        RS_IDLE,
        RS_SUB_T,
        RS_BIAS,
        RS_DIV,
        RS_DONE
    } t_ramp_state;

    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_EVAL,
        SQ_RAMP,
        SQ_DONE
    } t_seq_state;

endpackage

`default_nettype wire

>>> rtl/fes_apb_regs.sv
// fes_apb_regs: APB-style configuration registers of the fade envelope sequencer
// depends on fes_pkg
`default_nettype none

module fes_apb_regs
    import fes_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output t_cfg             o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic [1:0] reg_idx;

    assign reg_idx = paddr[3:2];
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (psel && penable && pwrite) begin
            unique case (reg_idx)
                REG_FADE_IN:  n_cfg.fade_in_time  = pwdata[DUR_W-1:0];
                REG_HOLD:     n_cfg.hold_time     = pwdata[DUR_W-1:0];
                REG_FADE_OUT: n_cfg.fade_out_time = pwdata[DUR_W-1:0];
                REG_PAUSE:    n_cfg.pause_at_mid  = pwdata[0];
                default:      n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_FADE_IN:  prdata = {16'd0, r_cfg.fade_in_time};
            REG_HOLD:     prdata = {16'd0, r_cfg.hold_time};
            REG_FADE_OUT: prdata = {16'd0, r_cfg.fade_out_time};
            REG_PAUSE:    prdata = {31'd0, r_cfg.pause_at_mid};
            default:      prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fade_in_time  <= DUR_RESET;
            r_cfg.hold_time     <= DUR_RESET;
            r_cfg.fade_out_time <= DUR_RESET;
            r_cfg.pause_at_mid  <= 1'b1;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

`default_nettype wire

>>> rtl/fes_ramp_unit.sv
// fes_ramp_unit: iterative ceil(t*255/d) clamped to 255, one shared adder
// depends on fes_pkg
`default_nettype none

module fes_ramp_unit
    import fes_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_ramp_req i_req,
    output t_ramp_rsp      o_rsp
);

    t_ramp_state r_state, n_state;
    logic [REM_W-1:0]   r_rem, n_rem;
    logic [REM_W-1:0]   r_dsh, n_dsh;
    logic [TIMER_W-1:0] r_t, n_t;
    logic [DUR_W-1:0]   r_d, n_d;
    logic [ALPHA_W-1:0] r_q, n_q;
    logic [3:0]         r_cnt, n_cnt;

    logic [DUR_W-1:0] d_eff;
    logic [REM_W-1:0] op_b;
    logic             cin;
    logic [REM_W:0]   sum;
    logic             no_borrow;

    assign d_eff     = (i_req.d == '0) ? DUR_W'(1) : i_req.d;
    assign sum       = {1'b0, r_rem} + {1'b0, op_b} + {{REM_W{1'b0}}, cin};
    assign no_borrow = sum[REM_W];

    always_comb begin
        unique case (r_state)
            RS_SUB_T: begin
                op_b = ~{{ALPHA_W{1'b0}}, r_t};
                cin  = 1'b1;
            end
            RS_BIAS: begin
                op_b = {{(REM_W-DUR_W){1'b0}}, r_d - DUR_W'(1)};
                cin  = 1'b0;
            end
            default: begin
                op_b = ~r_dsh;
                cin  = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_rem   = r_rem;
        n_dsh   = r_dsh;
        n_t     = r_t;
        n_d     = r_d;
        n_q     = r_q;
        n_cnt   = r_cnt;
        o_rsp.done     = 1'b0;
        o_rsp.quotient = r_q;
        unique case (r_state)
            RS_IDLE: begin
                if (i_req.start) begin
                    n_rem   = {i_req.t, {ALPHA_W{1'b0}}};
                    n_dsh   = {1'b0, d_eff, {ALPHA_W{1'b0}}};
                    n_t     = i_req.t;
                    n_d     = d_eff;
                    n_q     = '0;
                    n_cnt   = '0;
                    n_state = RS_SUB_T;
                end
            end
            RS_SUB_T: begin
                n_rem   = sum[REM_W-1:0];
                n_state = RS_BIAS;
            end
            RS_BIAS: begin
                n_rem   = sum[REM_W-1:0];
                n_state = RS_DIV;
            end
            RS_DIV: begin
                if (no_borrow) begin
                    n_rem = sum[REM_W-1:0];
                end
                n_dsh = r_dsh >> 1;
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'd0) begin
                    // quotient of 256 or more clamps to full scale
                    if (no_borrow) begin
                        n_q     = ALPHA_FULL;
                        n_state = RS_DONE;
                    end
                end else begin
                    n_q = {r_q[ALPHA_W-2:0], no_borrow};
                    if (r_cnt == 4'(ALPHA_W)) begin
                        n_state = RS_DONE;
                    end
                end
            end
            RS_DONE: begin
                o_rsp.done = 1'b1;
                n_state    = RS_IDLE;
            end
            default: n_state = RS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= RS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_dsh <= n_dsh;
        r_t   <= n_t;
        r_d   <= n_d;
        r_q   <= n_q;
        r_cnt <= n_cnt;
    end

endmodule

`default_nettype wire

>>> rtl/fade_envelope_sequencer.sv
// fade_envelope_sequencer: top level, envelope sequencer with shared ramp divider
// depends on fes_pkg, fes_apb_regs, fes_ramp_unit
//
// channel   direction  handshake            payload
// input     in         i_valid / o_ready    i_data  (t_in_item)
// output    out        o_valid / i_ready    o_data  (t_out_item)
// config    in         psel/penable/pwrite  paddr, pwdata, prdata, pready
//
// restart, allow and unused commands go straight to the result state, ticks via evaluation;
// alpha ticks use the divider's 9 compare-subtract steps, ending after the first on clamp
// o_ready is high only while the sequencer is idle
// a finished result waits in the output register; the next transfer is taken meanwhile
// synchronous active-low reset clears all envelope state and restores default timings
`default_nettype none

module fade_envelope_sequencer
    import fes_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire t_in_item    i_data,
    output logic             o_valid,
    input  wire logic        i_ready,
    output t_out_item        o_data,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    t_cfg      cfg;
    t_ramp_req ramp_req;
    t_ramp_rsp ramp_rsp;

    t_seq_state r_state, n_state;
    logic [TIMER_W-1:0] r_timer, n_timer;
    logic               r_running, n_running;
    logic               r_fading_in, n_fading_in;
    logic               r_holding, n_holding;
    logic               r_at_mid, n_at_mid;
    logic               r_allowed, n_allowed;
    logic [ALPHA_W-1:0] r_alpha, n_alpha;
    logic               r_mid_ev, n_mid_ev;
    logic               r_end_ev, n_end_ev;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out, n_out;

    logic [TIMER_W:0] timer_sum;
    logic [2:0]       phase;

    fes_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    fes_ramp_unit u_ramp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (ramp_req),
        .o_rsp   (ramp_rsp)
    );

    assign o_ready   = (r_state == SQ_IDLE);
    assign o_valid   = r_out_valid;
    assign o_data    = r_out;
    assign timer_sum = {1'b0, r_timer} + {{(TIMER_W+1-ELAP_W){1'b0}}, i_data.elapsed};

    always_comb begin
        priority if (r_fading_in) begin
            phase = PHASE_FADE_IN;
        end else if (r_holding) begin
            phase = PHASE_HOLD;
        end else if (r_at_mid) begin
            phase = r_running ? PHASE_FADE_OUT : PHASE_AT_MID;
        end else begin
            phase = PHASE_IDLE;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_timer     = r_timer;
        n_running   = r_running;
        n_fading_in = r_fading_in;
        n_holding   = r_holding;
        n_at_mid    = r_at_mid;
        n_allowed   = r_allowed;
        n_alpha     = r_alpha;
        n_mid_ev    = r_mid_ev;
        n_end_ev    = r_end_ev;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_ready;
        ramp_req.start = 1'b0;
        ramp_req.t     = r_timer;
        ramp_req.d     = r_fading_in ? cfg.fade_in_time : cfg.fade_out_time;

        unique case (r_state)
            SQ_IDLE: begin
                if (i_valid) begin
                    n_mid_ev = 1'b0;
                    n_end_ev = 1'b0;
                    n_state  = SQ_DONE;
                    unique case (i_data.func)
                        FUNC_RESTART: begin
                            n_allowed   = 1'b0;
                            n_holding   = 1'b0;
                            n_at_mid    = 1'b0;
                            n_fading_in = 1'b1;
                            n_alpha     = '0;
                            n_timer     = '0;
                            n_running   = 1'b1;
                        end
                        FUNC_ALLOW: n_allowed = 1'b1;
                        FUNC_TICK: begin
                            if (r_running) begin
                                n_timer = timer_sum[TIMER_W] ? TIMER_MAX
                                                             : timer_sum[TIMER_W-1:0];
                            end
                            n_state = SQ_EVAL;
                        end
                        default: n_state = SQ_DONE;
                    endcase
                end
            end
            SQ_EVAL: begin
                n_state = SQ_DONE;
                priority if (r_fading_in) begin
                    ramp_req.start = 1'b1;
                    n_state        = SQ_RAMP;
                end else if (r_holding) begin
                    if (r_timer >= {1'b0, cfg.hold_time}) begin
                        n_timer   = '0;
                        n_running = 1'b0;
                        n_at_mid  = 1'b1;
                        n_holding = 1'b0;
                        n_mid_ev  = 1'b1;
                        if (!cfg.pause_at_mid) begin
                            n_allowed = 1'b1;
                        end
                    end
                end else if (r_at_mid && r_allowed) begin
                    if (r_alpha == ALPHA_FULL && !r_running) begin
                        n_timer   = '0;
                        n_running = 1'b1;
                    end else begin
                        ramp_req.start = 1'b1;
                        n_state        = SQ_RAMP;
                    end
                end
            end
            SQ_RAMP: begin
                if (ramp_rsp.done) begin
                    n_state = SQ_DONE;
                    if (r_fading_in) begin
                        n_alpha = ramp_rsp.quotient;
                        if (r_timer >= {1'b0, cfg.fade_in_time}) begin
                            n_timer     = '0;
                            n_running   = 1'b1;
                            n_holding   = 1'b1;
                            n_fading_in = 1'b0;
                        end
                    end else begin
                        n_alpha = ALPHA_FULL - ramp_rsp.quotient;
                        if (r_timer >= {1'b0, cfg.fade_out_time}) begin
                            n_timer   = '0;
                            n_running = 1'b0;
                            n_end_ev  = 1'b1;
                            n_at_mid  = 1'b0;
                            n_allowed = 1'b0;
                        end
                    end
                end
            end
            SQ_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid     = 1'b1;
                    n_out.alpha     = r_alpha;
                    n_out.mid_event = r_mid_ev;
                    n_out.end_event = r_end_ev;
                    n_out.phase     = phase;
                    n_state         = SQ_IDLE;
                end
            end
            default: n_state = SQ_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= SQ_IDLE;
            r_timer     <= '0;
            r_running   <= 1'b0;
            r_fading_in <= 1'b0;
            r_holding   <= 1'b0;
            r_at_mid    <= 1'b0;
            r_allowed   <= 1'b0;
            r_alpha     <= '0;
            r_mid_ev    <= 1'b0;
            r_end_ev    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_timer     <= n_timer;
            r_running   <= n_running;
            r_fading_in <= n_fading_in;
            r_holding   <= n_holding;
            r_at_mid    <= n_at_mid;
            r_allowed   <= n_allowed;
            r_alpha     <= n_alpha;
            r_mid_ev    <= n_mid_ev;
            r_end_ev    <= n_end_ev;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

endmodule

`default_nettype wire

>>> bench/fes_checker.sv
// fes_checker: watches the command, result and register ports of the envelope sequencer
// predicts every result from its own copy of timings and envelope state; depends on fes_pkg
`timescale 1ns / 1ps

module fes_checker
    import fes_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cmd_valid,
    input  wire logic        i_cmd_ready,
    input  t_in_item         i_cmd,
    input  wire logic        i_res_valid,
    input  wire logic        i_res_ready,
    input  t_out_item        i_res,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,
    output int               o_mismatches,
    output int               o_pending,
    output int               o_checked
);

    t_cfg               timings;
    logic [TIMER_W-1:0] timer;
    logic               running;
    logic               fading_in;
    logic               holding;
    logic               at_mid;
    logic               out_allowed;
    logic [ALPHA_W-1:0] alpha;

    t_out_item expected_envelope[$];
    int        mismatches = 0;
    int        pending    = 0;
    int        checked    = 0;

    assign o_mismatches = mismatches;
    assign o_pending    = pending;
    assign o_checked    = checked;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    function automatic logic [ALPHA_W-1:0] alpha_ramp(input logic [TIMER_W-1:0] t,
                                                      input logic [DUR_W-1:0] dur);
        logic [31:0] d;
        logic [31:0] q;
        d = (dur == '0) ? 32'd1 : {16'b0, dur};
        q = ({15'b0, t} * 32'd255 + d - 32'd1) / d;
        return (q > 32'd255) ? ALPHA_FULL : q[ALPHA_W-1:0];
    endfunction

    task automatic advance_envelope(input t_in_item cmd, output t_out_item res);
        logic [TIMER_W:0] sum;
        logic             mid_ev;
        logic             end_ev;
        mid_ev = 1'b0;
        end_ev = 1'b0;
        case (cmd.func)
            FUNC_RESTART: begin
                out_allowed = 1'b0;
                holding     = 1'b0;
                at_mid      = 1'b0;
                fading_in   = 1'b1;
                alpha       = '0;
                timer       = '0;
                running     = 1'b1;
            end
            FUNC_ALLOW: begin
                out_allowed = 1'b1;
            end
            FUNC_TICK: begin
                if (running) begin
                    sum   = {1'b0, timer} + cmd.elapsed;
                    timer = (sum > TIMER_MAX) ? TIMER_MAX : sum[TIMER_W-1:0];
                end
                if (fading_in) begin
                    alpha = alpha_ramp(timer, timings.fade_in_time);
                    if (timer >= timings.fade_in_time) begin
                        timer     = '0;
                        running   = 1'b1;
                        holding   = 1'b1;
                        fading_in = 1'b0;
                    end
                end else if (holding) begin
                    if (timer >= timings.hold_time) begin
                        timer   = '0;
                        running = 1'b0;
                        at_mid  = 1'b1;
                        holding = 1'b0;
                        mid_ev  = 1'b1;
                        if (!timings.pause_at_mid) out_allowed = 1'b1;
                    end
                end else if (at_mid && out_allowed) begin
                    if (alpha == ALPHA_FULL && !running) begin
                        timer   = '0;
                        running = 1'b1;
                    end else begin
                        alpha = ALPHA_FULL - alpha_ramp(timer, timings.fade_out_time);
                        if (timer >= timings.fade_out_time) begin
                            timer       = '0;
                            running     = 1'b0;
                            end_ev      = 1'b1;
                            at_mid      = 1'b0;
                            out_allowed = 1'b0;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        res.alpha     = alpha;
        res.mid_event = mid_ev;
        res.end_event = end_ev;
        res.phase     = fading_in ? PHASE_FADE_IN :
                        holding   ? PHASE_HOLD :
                        at_mid    ? (running ? PHASE_FADE_OUT : PHASE_AT_MID) :
                                    PHASE_IDLE;
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            timings.fade_in_time  = DUR_RESET;
            timings.hold_time     = DUR_RESET;
            timings.fade_out_time = DUR_RESET;
            timings.pause_at_mid  = 1'b1;
            timer       = '0;
            running     = 1'b0;
            fading_in   = 1'b0;
            holding     = 1'b0;
            at_mid      = 1'b0;
            out_allowed = 1'b0;
            alpha       = '0;
            expected_envelope.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_FADE_IN:  timings.fade_in_time  = pwdata[DUR_W-1:0];
                    REG_HOLD:     timings.hold_time     = pwdata[DUR_W-1:0];
                    REG_FADE_OUT: timings.fade_out_time = pwdata[DUR_W-1:0];
                    REG_PAUSE:    timings.pause_at_mid  = pwdata[0];
                    default: begin
                    end
                endcase
            end
            if (i_res_valid && i_res_ready) begin
                if (expected_envelope.size() == 0) begin
                    report_mismatch("result with nothing pending, alpha", i_res.alpha, -1);
                end else begin
                    want = expected_envelope.pop_front();
                    checked++;
                    if (i_res.alpha !== want.alpha)
                        report_mismatch("alpha", i_res.alpha, want.alpha);
                    if (i_res.mid_event !== want.mid_event)
                        report_mismatch("mid_event", i_res.mid_event, want.mid_event);
                    if (i_res.end_event !== want.end_event)
                        report_mismatch("end_event", i_res.end_event, want.end_event);
                    if (i_res.phase !== want.phase)
                        report_mismatch("phase", i_res.phase, want.phase);
                end
            end
            if (i_cmd_valid && i_cmd_ready) begin
                advance_envelope(i_cmd, want);
                expected_envelope.push_back(want);
            end
        end
        pending = expected_envelope.size();
    end

endmodule

>>> bench/tb_fade_envelope_sequencer.sv
// tb_fade_envelope_sequencer: drives commands, register writes and result back-pressure
// into the fade envelope sequencer; fes_checker does the prediction; depends on fes_pkg
`timescale 1ns / 1ps

module tb_fade_envelope_sequencer
    import fes_pkg::*;
();

    localparam logic [1:0] FUNC_UNUSED       = 2'd3;
    localparam int         SETTLE_CYCLES     = 40;
    localparam int         RANDOM_SETTINGS   = 8;
    localparam int         ITEMS_PER_SETTING = 250;
    localparam int         HOLD_OFF_AFTER    = 300;
    localparam int         HOLD_OFF_CYCLES   = 400;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        i_ready = 1'b0;
    t_in_item    i_data  = '0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [3:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;

    logic        o_ready;
    logic        o_valid;
    t_out_item   o_data;
    logic [31:0] prdata;
    logic        pready;

    int   mismatches;
    int   pending;
    int   checked;
    int   sent         = 0;
    int   settings_run = 0;
    bit   held_off     = 1'b0;
    t_cfg timings;

    always #2 i_clk = ~i_clk;

    fade_envelope_sequencer uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    fes_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (i_valid),
        .i_cmd_ready  (o_ready),
        .i_cmd        (i_data),
        .i_res_valid  (o_valid),
        .i_res_ready  (i_ready),
        .i_res        (o_data),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    task automatic send_cmd(input logic [1:0] func, input logic [ELAP_W-1:0] elapsed);
        int gap;
        int r;
        r   = $urandom_range(0, 99);
        gap = (r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_data  <= {func, elapsed};
        do @(posedge i_clk); while (!o_ready);
        sent++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic program_timings(input logic [DUR_W-1:0] fade_in, input logic [DUR_W-1:0] hold,
                                   input logic [DUR_W-1:0] fade_out, input logic pause);
        timings = '{fade_in_time: fade_in, hold_time: hold, fade_out_time: fade_out,
                    pause_at_mid: pause};
        write_reg(REG_FADE_IN, {16'b0, fade_in});
        write_reg(REG_HOLD, {16'b0, hold});
        write_reg(REG_FADE_OUT, {16'b0, fade_out});
        write_reg(REG_PAUSE, {31'b0, pause});
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [ELAP_W-1:0] pick_elapsed();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return '0;
        if (r == 1) return '1;
        if (r < 4) return ELAP_W'($urandom_range(0, 15));
        return ELAP_W'($urandom_range(0, 1023));
    endfunction

    function automatic logic [DUR_W-1:0] pick_duration();
        int r;
        r = $urandom_range(0, 3);
        if (r == 0) return DUR_W'($urandom_range(0, 64));
        if (r == 1) return DUR_W'($urandom_range(1, 3000));
        if (r == 2) return DUR_W'($urandom_range(0, 65535));
        r = $urandom_range(0, 2);
        return (r == 0) ? 16'd0 : (r == 1) ? 16'd1 : 16'hFFFF;
    endfunction

    // result side back-pressure, with one long hold-off so the block fills up
    initial begin
        int len;
        int r;
        forever begin
            @(negedge i_clk);
            if (!held_off && checked >= HOLD_OFF_AFTER) begin
                held_off = 1'b1;
                i_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    i_ready <= 1'b1;
                    len = $urandom_range(1, 30);
                end else if (r < 95) begin
                    i_ready <= 1'b0;
                    len = $urandom_range(1, 3);
                end else begin
                    i_ready <= 1'b0;
                    len = $urandom_range(10, 60);
                end
                repeat (len - 1) @(negedge i_clk);
            end
        end
    end

    initial begin
        int n;
        int seq_ticks;
        timings = '{fade_in_time: DUR_RESET, hold_time: DUR_RESET, fade_out_time: DUR_RESET,
                    pause_at_mid: 1'b1};
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // default timings: idle commands, then a full envelope paused at mid
        send_cmd(FUNC_TICK, '0);
        send_cmd(FUNC_UNUSED, '1);
        send_cmd(FUNC_ALLOW, '0);
        send_cmd(FUNC_RESTART, '1);
        send_cmd(FUNC_TICK, 10'd1);
        send_cmd(FUNC_TICK, '1);
        send_cmd(FUNC_TICK, '1);
        send_cmd(FUNC_TICK, '1);
        send_cmd(FUNC_ALLOW, '0);
        send_cmd(FUNC_TICK, 10'd512);
        send_cmd(FUNC_TICK, 10'd1);
        send_cmd(FUNC_TICK, '1);
        send_cmd(FUNC_TICK, '1);

        // zero durations, no pause
        wait_idle();
        program_timings('0, '0, '0, 1'b0);
        send_cmd(FUNC_RESTART, '0);
        send_cmd(FUNC_TICK, '0);
        send_cmd(FUNC_TICK, '0);
        send_cmd(FUNC_TICK, '0);

        // mid reached below full alpha with the timer stopped
        wait_idle();
        program_timings('0, '0, 16'd1000, 1'b0);
        send_cmd(FUNC_RESTART, '0);
        send_cmd(FUNC_TICK, '0);
        send_cmd(FUNC_TICK, '0);
        send_cmd(FUNC_TICK, '0);
        send_cmd(FUNC_TICK, 10'd7);
        send_cmd(FUNC_TICK, '1);
        send_cmd(FUNC_RESTART, '0);
        send_cmd(FUNC_TICK, 10'd3);

        for (int s = 0; s < RANDOM_SETTINGS; s++) begin
            wait_idle();
            if (s == 0)
                program_timings('1, '1, '1, 1'b1);
            else if (s == 1)
                program_timings(16'd1, '0, 16'd1, 1'b0);
            else
                program_timings(pick_duration(), pick_duration(), pick_duration(),
                                1'($urandom_range(0, 1)));
            n = 0;
            while (n < ITEMS_PER_SETTING) begin
                if ($urandom_range(0, 9) < 8) begin
                    send_cmd(FUNC_RESTART, ELAP_W'($urandom));
                    n++;
                    seq_ticks = (int'(timings.fade_in_time) + int'(timings.hold_time)
                                 + int'(timings.fade_out_time)) / 300 + $urandom_range(3, 8);
                    for (int k = 0; k < seq_ticks; k++) begin
                        if ($urandom_range(0, 7) == 0) begin
                            send_cmd(FUNC_ALLOW, ELAP_W'($urandom));
                            n++;
                        end
                        send_cmd(FUNC_TICK, pick_elapsed());
                        n++;
                    end
                end else begin
                    repeat ($urandom_range(1, 10)) begin
                        send_cmd(2'($urandom_range(0, 3)), ELAP_W'($urandom));
                        n++;
                    end
                end
            end
            settings_run++;
        end

        wait_idle();
        $display("sent %0d commands: directed envelopes plus %0d random timing settings",
                 sent, settings_run);
        $display("%0d results compared field by field, %0d mismatches", checked, mismatches);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #8_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
